// File: rtl/idffc_pkg.sv
package idffc_pkg;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SAT   = 2'd1,
		ST_UNDER = 2'd2,
		ST_OVER  = 2'd3
	} status_t;

	typedef enum logic {
		KIND_TO_DSP  = 1'b0,
		KIND_TO_IEEE = 1'b1
	} kind_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] operand_in;
	} in_item_t;

	typedef struct packed {
		logic [31:0] operand_out;
		logic [1:0]  status;
	} out_item_t;

	localparam logic [31:0] DSP_ZERO   = 32'h8000_0000;
	localparam logic [22:0] FRAC_MASK  = 23'h7f_ffff;
	localparam logic [23:0] HIDDEN_BIT = 24'h80_0000;
	localparam logic [7:0]  ZERO_EXP   = 8'h80;

endpackage

// File: rtl/idffc_convert.sv
module idffc_convert (
	input  idffc_pkg::in_item_t  in_item,
	output idffc_pkg::out_item_t out_item
);
	import idffc_pkg::*;

	// Forward direction.
	logic        f_s;
	logic [7:0]  f_be;
	logic [22:0] f_m;
	logic [7:0]  f_e;
	logic [23:0] f_mag;
	logic [23:0] f_neg;
	logic [31:0] f_res;
	status_t     f_st;

	// Reverse direction.
	logic [7:0]  r_e;
	logic        r_s;
	logic [22:0] r_f;
	logic [24:0] r_mag;
	logic [8:0]  r_b;
	logic [23:0] r_q;
	logic [31:0] r_res;
	status_t     r_st;

	always_comb begin
		f_s   = in_item.operand_in[31];
		f_be  = in_item.operand_in[30:23];
		f_m   = in_item.operand_in[22:0];
		f_st  = ST_OK;
		f_res = DSP_ZERO;
		// Exponent byte is be - 127, i.e. be + 129 modulo 256.
		f_e   = f_be + 8'd129;
		f_mag = {1'b1, f_m};
		if (f_be == 8'd0) begin
			f_e   = 8'h81;
			f_mag = {f_m, 1'b0};
		end
		f_neg = 24'd0 - f_mag;
		if (f_be == 8'hff) begin
			f_st  = ST_SAT;
			f_res = f_s ? 32'h7F80_0000 : 32'h7F7F_FFFF;
		end else if (f_be == 8'd0 && f_m == 23'd0) begin
			f_res = DSP_ZERO;
		end else if (f_be == 8'd0 && !f_m[22]) begin
			f_st  = ST_UNDER;
			f_res = DSP_ZERO;
		end else if (!f_s) begin
			f_res = {f_e, 1'b0, f_mag[22:0]};
		end else if (f_mag == HIDDEN_BIT) begin
			// Lowering -127 reaches the zero exponent and flushes.
			if (f_e == 8'h81) begin
				f_st  = ST_UNDER;
				f_res = DSP_ZERO;
			end else begin
				f_res = {f_e - 8'd1, 1'b1, 23'd0};
			end
		end else begin
			f_res = {f_e, 1'b1, f_neg[22:0] & FRAC_MASK};
		end
	end

	always_comb begin
		r_e   = in_item.operand_in[31:24];
		r_s   = in_item.operand_in[23];
		r_f   = in_item.operand_in[22:0];
		r_st  = ST_OK;
		r_b   = {r_e[7], r_e} + 9'd127;
		r_mag = r_s ? (25'h100_0000 - {2'b00, r_f}) : {2'b01, r_f};
		if (r_mag[24]) begin
			r_mag = {1'b0, HIDDEN_BIT};
			r_b   = r_b + 9'd1;
		end
		r_q   = r_mag[24:1];
		if (r_mag[0] && r_q[0])
			r_q = r_q + 24'd1;
		if (r_e == ZERO_EXP) begin
			r_res = 32'd0;
		end else if (!r_b[8] && r_b == 9'd255) begin
			r_st  = ST_OVER;
			r_res = {r_s, 31'h7F80_0000};
		end else if (!r_b[8] && r_b != 9'd0) begin
			r_res = {r_s, r_b[7:0], r_mag[22:0]};
		end else begin
			r_res = {r_s, 7'd0, r_q};
		end
	end

	always_comb begin
		if (in_item.kind == KIND_TO_IEEE) begin
			out_item.operand_out = r_res;
			out_item.status      = r_st;
		end else begin
			out_item.operand_out = f_res;
			out_item.status      = f_st;
		end
	end

endmodule

// File: rtl/ieee_dsp_float_format_convert_top.sv
// IEEE single <-> DSP float word converter.
// Input channel in_valid/in_ready carries in_item: kind selects the direction
// (0 IEEE single to DSP word, 1 DSP word to IEEE single) and operand_in holds
// the source word. Output channel out_valid/out_ready carries out_item with
// the converted word and a status code (ok, saturated, underflow, overflow).
// Every beat in yields exactly one beat out, in order.
// An accepted beat is registered at the input, converted by a single level of
// combinational logic and captured in the output register, which presents it
// on out_valid/out_item until the receiver takes it.
// Throughput is one beat per cycle while out_ready stays high; both registers
// advance together whenever the output register is empty or being drained.
// When the receiver stalls, the output register holds its beat, the input
// register holds the next one, and in_ready drops until the stall clears.
// Reset clears both valid flags; no beat is pending afterwards.
module ieee_dsp_float_format_convert_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  idffc_pkg::in_item_t  in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output idffc_pkg::out_item_t out_item
);
	import idffc_pkg::*;

	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t conv;
	out_item_t item_s2;
	logic      valid_s2;
	logic      adv;

	assign adv      = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv;

	idffc_convert u_convert (
		.in_item  (item_s1),
		.out_item (conv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (adv)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			item_s1 <= in_item;
		if (adv && valid_s1)
			item_s2 <= conv;
	end

	assign out_valid = valid_s2;
	assign out_item  = item_s2;

`ifndef ASSERT_OFF
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_ready |=> valid_s2 && $stable(item_s2))
		else $error("output beat changed while stalled");
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !out_ready |-> !in_ready)
		else $error("input accepted while pipeline full");
	a_zero_map: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && item_s1.kind == KIND_TO_IEEE && item_s1.operand_in[31:24] == ZERO_EXP
		|-> conv.operand_out == 32'd0 && conv.status == ST_OK)
		else $error("zero exponent not mapped to +0.0");
`endif

endmodule
